>>> src/ctl_pkg.sv
// Shared types and constants for the change-compressed tick log.
// Used by the RAM wrapper users, the datapath, the controller and the top level.
package ctl_pkg;

  // Store geometry.
  localparam int LOG_DEPTH  = 1024;
  localparam int AXIS_COUNT = 4;
  localparam int AXIS_SLOTS = 4;
  localparam int WORD_W     = 32;
  localparam int HELD_W     = 11;
  localparam int IDX_W      = $clog2(LOG_DEPTH);
  localparam int CNT_W      = $clog2(LOG_DEPTH + 1);
  localparam int PAY_W      = WORD_W * (AXIS_COUNT + 1);

  // Operation codes carried by the mode field.
  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Read address selection for both stores.
  typedef enum logic [1:0] {
    RD_LAST  = 2'd0,
    RD_FIRST = 2'd1,
    RD_MID   = 2'd2,
    RD_LO    = 2'd3
  } ctl_rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_req;
    logic        rd_en;
    ctl_rd_sel_t rd_sel;
    logic        stage_clr;
    logic        set_ok;
    logic        raise;
    logic        append;
    logic        clear;
    logic        init_search;
    logic        step;
    logic        capture;
    logic        load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       cnt_zero;
    logic       full;
    logic       tick_gt;
    logic       same;
    logic       lo_lt_hi;
  } ctl_sts_t;

endpackage

>>> src/ctl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module ctl_ram #(
  parameter int  WIDTH  = 32,
  parameter int  DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/ctl_datapath.sv
// Datapath of the tick log: request register, count, latest tick, search bounds,
// the tick and payload stores, and the result registers. Depends on ctl_pkg and ctl_ram.
module ctl_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ctl_pkg::ctl_cmd_t                       cmd,
  output ctl_pkg::ctl_sts_t                       sts,
  input  logic [1:0]                              in_mode,
  input  logic [ctl_pkg::WORD_W-1:0]              in_tick,
  input  logic [ctl_pkg::AXIS_SLOTS-1:0][ctl_pkg::WORD_W-1:0] in_axes,
  input  logic [ctl_pkg::WORD_W-1:0]              in_buttons,
  output logic                                    res_ok,
  output logic [ctl_pkg::AXIS_SLOTS-1:0][ctl_pkg::WORD_W-1:0] res_axes,
  output logic [ctl_pkg::WORD_W-1:0]              res_buttons,
  output logic [ctl_pkg::WORD_W-1:0]              res_latest,
  output logic [ctl_pkg::HELD_W-1:0]              res_held
);
  import ctl_pkg::*;

  // Request register.
  logic [1:0]        req_mode;
  logic [WORD_W-1:0] req_tick;
  logic [PAY_W-1:0]  req_pay;
  logic [PAY_W-1:0]  in_pay;

  // Log state.
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_m1;
  logic [WORD_W-1:0] latest;

  // Search bounds.
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  mid;
  logic [IDX_W-1:0]  mid_r;
  logic [IDX_W:0]    span;

  // Store ports.
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] tick_rdata;
  logic [PAY_W-1:0]  pay_rdata;

  // Staged result of the current operation.
  logic              stage_ok;
  logic [PAY_W-1:0]  stage_pay;

  // Output registers.
  logic [PAY_W-1:0]  out_pay;

  // Pack the used axes with the button mask on top.
  for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_pack
    assign in_pay[k*WORD_W +: WORD_W] = in_axes[k];
  end
  assign in_pay[PAY_W-1 -: WORD_W] = in_buttons;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode <= in_mode;
      req_tick <= in_tick;
      req_pay  <= in_pay;
    end
  end

  // Count and latest tick.
  assign cnt_m1 = cnt - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      latest <= '0;
    end else if (cmd.clear) begin
      cnt    <= '0;
      latest <= '0;
    end else begin
      if (cmd.append) begin
        cnt <= cnt + CNT_W'(1);
      end
      if ((cmd.append || cmd.raise) && (req_tick > latest)) begin
        latest <= req_tick;
      end
    end
  end

  // Midpoint rounds up so the search always makes progress toward hi.
  assign span = {1'b0, hi} - {1'b0, lo} + (IDX_W+1)'(1);
  assign mid  = lo + span[IDX_W:1];

  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      lo <= '0;
      hi <= cnt_m1[IDX_W-1:0];
    end else if (cmd.step) begin
      if (tick_rdata > req_tick) begin
        hi <= mid_r - IDX_W'(1);
      end else begin
        lo <= mid_r;
      end
    end
    if (cmd.rd_en && (cmd.rd_sel == RD_MID)) begin
      mid_r <= mid;
    end
  end

  // Read address selection shared by both stores.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_LAST:  rd_addr = cnt_m1[IDX_W-1:0];
      RD_FIRST: rd_addr = '0;
      RD_MID:   rd_addr = mid;
      RD_LO:    rd_addr = lo;
    endcase
  end

  ctl_ram #(.WIDTH(WORD_W), .DEPTH(LOG_DEPTH)) u_tick_ram (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (cnt[IDX_W-1:0]),
    .wr_data (req_tick),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (tick_rdata)
  );

  ctl_ram #(.WIDTH(PAY_W), .DEPTH(LOG_DEPTH)) u_pay_ram (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (cnt[IDX_W-1:0]),
    .wr_data (req_pay),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (pay_rdata)
  );

  // Status toward the controller.
  assign sts.mode     = req_mode;
  assign sts.cnt_zero = (cnt == '0);
  assign sts.full     = (cnt == CNT_W'(LOG_DEPTH));
  assign sts.tick_gt  = (tick_rdata > req_tick);
  assign sts.same     = (pay_rdata == req_pay);
  assign sts.lo_lt_hi = (lo < hi);

  // Staged result: ok flag and found payload.
  always_ff @(posedge clk) begin
    if (cmd.set_ok) begin
      stage_ok <= 1'b1;
    end else if (cmd.stage_clr) begin
      stage_ok <= 1'b0;
    end
    if (cmd.capture) begin
      stage_pay <= pay_rdata;
    end else if (cmd.stage_clr) begin
      stage_pay <= '0;
    end
  end

  // Result registers hold the word until it is taken.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_ok     <= stage_ok;
      out_pay    <= stage_pay;
      res_latest <= latest;
      res_held   <= HELD_W'(cnt);
    end
  end

  // Unpack result axes; unused slots read as zero.
  for (genvar k = 0; k < AXIS_SLOTS; k++) begin : g_unpack
    if (k < AXIS_COUNT) begin : g_used
      assign res_axes[k] = out_pay[k*WORD_W +: WORD_W];
    end else begin : g_unused
      assign res_axes[k] = '0;
    end
  end
  assign res_buttons = out_pay[PAY_W-1 -: WORD_W];

  // An append only happens while there is room.
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (cnt < CNT_W'(LOG_DEPTH)))
    else $error("append issued on a full log");

  // A search step only runs while the bounds are still open.
  a_step_open: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (lo < hi) && (mid_r > lo) && (mid_r <= hi))
    else $error("search step with collapsed bounds");

endmodule

>>> src/ctl_controller.sv
// Controller state machine for the tick log: sequences record, lookup and clear
// through the datapath and owns the input and output handshakes. Depends on ctl_pkg.
module ctl_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ctl_pkg::ctl_sts_t sts,
  output ctl_pkg::ctl_cmd_t cmd
);
  import ctl_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DECODE  = 11'b000_0000_0010,
    S_REC_RD  = 11'b000_0000_0100,
    S_REC_CHK = 11'b000_0000_1000,
    S_APPEND  = 11'b000_0001_0000,
    S_LK_RD0  = 11'b000_0010_0000,
    S_LK_CHK0 = 11'b000_0100_0000,
    S_LK_LOOP = 11'b000_1000_0000,
    S_LK_CMP  = 11'b001_0000_0000,
    S_LK_GOT  = 11'b010_0000_0000,
    S_RESP    = 11'b100_0000_0000
  } ctl_state_t;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       in_fire;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_LAST;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.stage_clr = 1'b1;
        priority if (sts.mode == MODE_RECORD) begin
          state_next = sts.cnt_zero ? S_APPEND : S_REC_RD;
        end else if (sts.mode == MODE_LOOKUP) begin
          state_next = sts.cnt_zero ? S_RESP : S_LK_RD0;
        end else if (sts.mode == MODE_CLEAR) begin
          cmd.clear  = 1'b1;
          cmd.set_ok = 1'b1;
          state_next = S_RESP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_REC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_next = S_REC_CHK;
      end
      S_REC_CHK: begin
        // Older tick is refused; an unchanged snapshot only raises latest; a full log refuses a change.
        priority if (sts.tick_gt) begin
          state_next = S_RESP;
        end else if (sts.same) begin
          cmd.raise  = 1'b1;
          cmd.set_ok = 1'b1;
          state_next = S_RESP;
        end else if (sts.full) begin
          state_next = S_RESP;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.set_ok = 1'b1;
        state_next = S_RESP;
      end
      S_LK_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FIRST;
        state_next = S_LK_CHK0;
      end
      S_LK_CHK0: begin
        // A query below the first tick has no floor entry.
        if (sts.tick_gt) begin
          state_next = S_RESP;
        end else begin
          cmd.init_search = 1'b1;
          state_next      = S_LK_LOOP;
        end
      end
      S_LK_LOOP: begin
        cmd.rd_en = 1'b1;
        if (sts.lo_lt_hi) begin
          cmd.rd_sel = RD_MID;
          state_next = S_LK_CMP;
        end else begin
          cmd.rd_sel = RD_LO;
          state_next = S_LK_GOT;
        end
      end
      S_LK_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_LK_LOOP;
      end
      S_LK_GOT: begin
        cmd.capture = 1'b1;
        cmd.set_ok  = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result register is only overwritten once its word has been taken.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending word");

  // Each accepted word yields exactly one result before the next is taken.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) && out_free |=> (state == S_IDLE) && out_valid)
    else $error("result not delivered on leaving response state");

endmodule

>>> src/change_compressed_tick_log.sv
// Top level of the change-compressed tick log; depends on ctl_pkg, ctl_controller, ctl_datapath.
// Accept to result valid differs by path: clear or unused mode, record on an empty log, when
// refused or unchanged, or on an append; lookup when empty, below the first tick, or when found
// by a binary search over the stored ticks.
// One word is in work at a time: the next is taken in the cycle after its result is loaded.
// Reset (synchronous) zeroes the count and latest tick; the stores are not cleared.
module change_compressed_tick_log_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [ctl_pkg::WORD_W-1:0]     tick,
  input  logic [ctl_pkg::WORD_W-1:0]     axis_0,
  input  logic [ctl_pkg::WORD_W-1:0]     axis_1,
  input  logic [ctl_pkg::WORD_W-1:0]     axis_2,
  input  logic [ctl_pkg::WORD_W-1:0]     axis_3,
  input  logic [ctl_pkg::WORD_W-1:0]     buttons,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ok,
  output logic [ctl_pkg::WORD_W-1:0]     out_axis_0,
  output logic [ctl_pkg::WORD_W-1:0]     out_axis_1,
  output logic [ctl_pkg::WORD_W-1:0]     out_axis_2,
  output logic [ctl_pkg::WORD_W-1:0]     out_axis_3,
  output logic [ctl_pkg::WORD_W-1:0]     out_buttons,
  output logic [ctl_pkg::WORD_W-1:0]     latest_tick_seen,
  output logic [ctl_pkg::HELD_W-1:0]     entries_held
);
  import ctl_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic [AXIS_SLOTS-1:0][WORD_W-1:0] res_axes;

  // Sequencer.
  ctl_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stores, search bounds and result registers.
  ctl_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (mode),
    .in_tick     (tick),
    .in_axes     ({axis_3, axis_2, axis_1, axis_0}),
    .in_buttons  (buttons),
    .res_ok      (ok),
    .res_axes    (res_axes),
    .res_buttons (out_buttons),
    .res_latest  (latest_tick_seen),
    .res_held    (entries_held)
  );

  assign out_axis_0 = res_axes[0];
  assign out_axis_1 = res_axes[1];
  assign out_axis_2 = res_axes[2];
  assign out_axis_3 = res_axes[3];

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the change-compressed tick log core.
// It holds its own model of the log, drives directed and random words and checks every result.
// Depends on ctl_pkg and change_compressed_tick_log_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctl_pkg::*;

  // Mode value that the block treats as unused.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LONG_HOLD = 200;

  typedef struct packed {
    logic [1:0]                        mode;
    logic [WORD_W-1:0]                 tick;
    logic [AXIS_SLOTS-1:0][WORD_W-1:0] axes;
    logic [WORD_W-1:0]                 buttons;
  } log_word_t;

  typedef struct packed {
    logic                              ok;
    logic [AXIS_SLOTS-1:0][WORD_W-1:0] axes;
    logic [WORD_W-1:0]                 buttons;
    logic [WORD_W-1:0]                 latest;
    logic [HELD_W-1:0]                 held;
  } log_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        mode;
  logic [WORD_W-1:0] tick;
  logic [WORD_W-1:0] axis_0;
  logic [WORD_W-1:0] axis_1;
  logic [WORD_W-1:0] axis_2;
  logic [WORD_W-1:0] axis_3;
  logic [WORD_W-1:0] buttons;
  logic              out_valid;
  logic              out_ready;
  logic              ok;
  logic [WORD_W-1:0] out_axis_0;
  logic [WORD_W-1:0] out_axis_1;
  logic [WORD_W-1:0] out_axis_2;
  logic [WORD_W-1:0] out_axis_3;
  logic [WORD_W-1:0] out_buttons;
  logic [WORD_W-1:0] latest_tick_seen;
  logic [HELD_W-1:0] entries_held;

  // Model copy of the log contents.
  logic [WORD_W-1:0]                 log_tick    [LOG_DEPTH];
  logic [AXIS_SLOTS-1:0][WORD_W-1:0] log_axes    [LOG_DEPTH];
  logic [WORD_W-1:0]                 log_buttons [LOG_DEPTH];
  int unsigned                       log_count  = 0;
  logic [WORD_W-1:0]                 log_latest = '0;

  log_result_t pending_results[$];
  log_result_t want;

  bit          idle_on       = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          reached_full  = 1'b0;
  int unsigned error_count     = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned lookups_found   = 0;
  int unsigned refusals        = 0;

  change_compressed_tick_log_core DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .tick             (tick),
    .axis_0           (axis_0),
    .axis_1           (axis_1),
    .axis_2           (axis_2),
    .axis_3           (axis_3),
    .buttons          (buttons),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .ok               (ok),
    .out_axis_0       (out_axis_0),
    .out_axis_1       (out_axis_1),
    .out_axis_2       (out_axis_2),
    .out_axis_3       (out_axis_3),
    .out_buttons      (out_buttons),
    .latest_tick_seen (latest_tick_seen),
    .entries_held     (entries_held)
  );

  always #2 clk = ~clk;

  // Apply one word to the model log and return the result it should produce.
  function automatic log_result_t apply_to_log(log_word_t w);
    log_result_t r;
    bit          dup;
    int          hit;
    r   = '0;
    dup = 1'b0;
    hit = -1;
    case (w.mode)
      MODE_RECORD: begin
        if (log_count != 0 && w.tick < log_tick[log_count-1]) begin
          r.ok = 1'b0;
        end else begin
          if (log_count != 0) begin
            dup = (log_buttons[log_count-1] == w.buttons);
            for (int a = 0; a < AXIS_COUNT; a++) begin
              if (log_axes[log_count-1][a] != w.axes[a]) dup = 1'b0;
            end
          end
          if (dup) begin
            r.ok = 1'b1;
            if (w.tick > log_latest) log_latest = w.tick;
          end else if (log_count >= LOG_DEPTH) begin
            r.ok = 1'b0;
          end else begin
            log_tick[log_count]    = w.tick;
            log_axes[log_count]    = '0;
            for (int a = 0; a < AXIS_COUNT; a++) log_axes[log_count][a] = w.axes[a];
            log_buttons[log_count] = w.buttons;
            log_count++;
            if (w.tick > log_latest) log_latest = w.tick;
            r.ok = 1'b1;
          end
        end
      end
      MODE_LOOKUP: begin
        // Ticks are kept in non-decreasing order, so the last qualifying entry is the floor.
        for (int i = 0; i < log_count; i++) begin
          if (log_tick[i] <= w.tick) hit = i;
        end
        if (hit >= 0) begin
          r.ok      = 1'b1;
          for (int a = 0; a < AXIS_COUNT; a++) r.axes[a] = log_axes[hit][a];
          r.buttons = log_buttons[hit];
        end
      end
      MODE_CLEAR: begin
        log_count  = 0;
        log_latest = '0;
        r.ok       = 1'b1;
      end
      default: r.ok = 1'b0;
    endcase
    r.latest = log_latest;
    r.held   = log_count[HELD_W-1:0];
    return r;
  endfunction

  function automatic log_word_t make_word(logic [1:0] m, logic [WORD_W-1:0] t,
                                          logic [WORD_W-1:0] a0, logic [WORD_W-1:0] a1,
                                          logic [WORD_W-1:0] a2, logic [WORD_W-1:0] a3,
                                          logic [WORD_W-1:0] btn);
    log_word_t w;
    w.mode    = m;
    w.tick    = t;
    w.axes[0] = a0;
    w.axes[1] = a1;
    w.axes[2] = a2;
    w.axes[3] = a3;
    w.buttons = btn;
    return w;
  endfunction

  // Random word: repeat_pct steers older ticks, repeated and near-repeated snapshots.
  function automatic log_word_t make_random_word(int unsigned record_pct,
                                                 int unsigned clear_pct,
                                                 int unsigned repeat_pct,
                                                 int unsigned tick_step);
    log_word_t   w;
    int unsigned pick;
    int unsigned fld;
    logic [WORD_W-1:0] base;
    w.mode    = MODE_LOOKUP;
    w.tick    = $urandom;
    for (int a = 0; a < AXIS_SLOTS; a++) w.axes[a] = $urandom;
    w.buttons = $urandom;
    base = (log_count == 0) ? $urandom : log_tick[log_count-1];
    pick = $urandom_range(0, 99);
    if (pick < record_pct) begin
      w.mode = MODE_RECORD;
      pick = $urandom_range(0, 99);
      if (pick < repeat_pct / 3) w.tick = base - $urandom_range(1, 40);
      else if (pick < repeat_pct / 3 + 6 && tick_step > 100) w.tick = $urandom;
      else w.tick = base + $urandom_range(0, tick_step);
      if (log_count != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 2 * repeat_pct) begin
          w.axes    = log_axes[log_count-1];
          w.buttons = log_buttons[log_count-1];
        end
        // A near repeat differs from the last entry in a single bit.
        if (pick >= repeat_pct && pick < 2 * repeat_pct) begin
          fld = $urandom_range(0, AXIS_COUNT);
          if (fld == AXIS_COUNT) begin
            pick = $urandom_range(0, WORD_W - 1);
            w.buttons[pick] = ~w.buttons[pick];
          end else begin
            pick = $urandom_range(0, WORD_W - 1);
            w.axes[fld][pick] = ~w.axes[fld][pick];
          end
        end
      end
    end else if (pick < record_pct + clear_pct) begin
      w.mode = MODE_CLEAR;
    end else if (pick < record_pct + clear_pct + 2) begin
      w.mode = MODE_UNUSED;
    end else if (log_count != 0 && $urandom_range(0, 99) >= 40) begin
      // Query around a stored tick to hit exact, just-below and just-above cases.
      w.tick = log_tick[$urandom_range(0, log_count - 1)] + $urandom_range(0, 2) - 32'd1;
    end
    return w;
  endfunction

  // Offer one word, wait for it to be taken, then record what it should produce.
  task automatic send_word(log_word_t w);
    log_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= w.mode;
    tick     <= w.tick;
    axis_0   <= w.axes[0];
    axis_1   <= w.axes[1];
    axis_2   <= w.axes[2];
    axis_3   <= w.axes[3];
    buttons  <= w.buttons;
    do @(posedge clk); while (!in_ready);
    r = apply_to_log(w);
    pending_results.push_back(r);
    words_sent++;
    if (w.mode == MODE_LOOKUP && r.ok) lookups_found++;
    if (!r.ok) refusals++;
    if (log_count == LOG_DEPTH) reached_full = 1'b1;
  endtask

  // Extremes and special cases of record, lookup, clear and the unused mode.
  task automatic test_directed_cases();
    send_word(make_word(MODE_LOOKUP, 32'd5, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_UNUSED, 32'd7, '1, '1, '1, '1, '1));
    send_word(make_word(MODE_RECORD, 32'd100, 32'h3F80_0000, 32'd1, 32'd2, 32'd3, 32'h11));
    send_word(make_word(MODE_RECORD, 32'd90, 32'd9, 32'd9, 32'd9, 32'd9, 32'h22));
    send_word(make_word(MODE_RECORD, 32'd150, 32'h3F80_0000, 32'd1, 32'd2, 32'd3, 32'h11));
    send_word(make_word(MODE_RECORD, 32'd120, 32'h3F80_0000, 32'd1, 32'd2, 32'd3, 32'h10));
    send_word(make_word(MODE_RECORD, 32'd120, 32'hBF80_0000, 32'd5, 32'd6, 32'd7, 32'h10));
    send_word(make_word(MODE_LOOKUP, 32'd99, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_LOOKUP, 32'd100, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_LOOKUP, 32'd119, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_LOOKUP, 32'd120, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_RECORD, '1, '1, '1, '1, '1, '1));
    send_word(make_word(MODE_RECORD, 32'd0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_LOOKUP, '1, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_LOOKUP, 32'hFFFF_FFFE, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_CLEAR, '1, '1, '1, '1, '1, '1));
    send_word(make_word(MODE_LOOKUP, 32'd0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_RECORD, 32'd0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_LOOKUP, 32'd0, '1, '1, '1, '1, '1));
    send_word(make_word(MODE_RECORD, 32'd0, '1, '1, '1, '1, '1));
    send_word(make_word(MODE_RECORD, 32'd0, '1, '1, '1, '1, '1));
    send_word(make_word(MODE_LOOKUP, 32'd0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_CLEAR, '0, '0, '0, '0, '0, '0));
  endtask

  // Random mix of all modes with full-range ticks and occasional clears.
  task automatic test_random_mixed();
    repeat (40) send_word(make_random_word(55, 4, 24, 1000));
  endtask

  // The receiver holds off for a long stretch while words keep being offered.
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (8) send_word(make_random_word(60, 0, 24, 1000));
  endtask

  // Fill the log to capacity, then keep pushing records and lookups into the full log.
  task automatic test_fill_to_capacity();
    send_word(make_word(MODE_CLEAR, '0, '0, '0, '0, '0, '0));
    while (log_count < LOG_DEPTH) begin
      if (log_count > 880) idle_on = 1'b0;
      send_word(make_random_word(99, 0, 2, 3));
    end
    repeat (20) send_word(make_random_word(70, 0, 30, 3));
  endtask

  // Receiver: random stall bursts, plus one long hold when asked for.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [WORD_W-1:0] exp_v,
                                      logic [WORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Compare every accepted result word with the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no expectation pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", {31'd0, want.ok}, {31'd0, ok});
        check_field("out_axis_0", want.axes[0], out_axis_0);
        check_field("out_axis_1", want.axes[1], out_axis_1);
        check_field("out_axis_2", want.axes[2], out_axis_2);
        check_field("out_axis_3", want.axes[3], out_axis_3);
        check_field("out_buttons", want.buttons, out_buttons);
        check_field("latest_tick_seen", want.latest, latest_tick_seen);
        check_field("entries_held", {21'd0, want.held}, {21'd0, entries_held});
        results_checked++;
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    mode     = MODE_RECORD;
    tick     = '0;
    axis_0   = '0;
    axis_1   = '0;
    axis_2   = '0;
    axis_3   = '0;
    buttons  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_mixed();
    test_output_backpressure();
    test_fill_to_capacity();
    in_valid <= 1'b0;

    // Drain outstanding results, then allow a lookup's worth of extra cycles.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d words and %0d checked results: %0d lookups hit, %0d refused.",
             words_sent, results_checked, lookups_found, refusals);
    $display("The log was filled to capacity: %0d; output hold of %0d cycles applied.",
             reached_full, LONG_HOLD);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
